// ===== hdl/adjacency_matrix_dfs_macros.svh =====
// ---------------------------------------------------------------------------
// adjacency_matrix_dfs_macros.svh
// Assertion macros for the adjacency matrix DFS block.
// ---------------------------------------------------------------------------
`ifndef ADJACENCY_MATRIX_DFS_MACROS_SVH
`define ADJACENCY_MATRIX_DFS_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define AMD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset
`define AMD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AMD_ASSERT_IMP(lbl, ante, cons, msg)
`define AMD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/amdfs_pkg.sv =====
// ---------------------------------------------------------------------------
// amdfs_pkg
// Types and constants shared by the adjacency matrix DFS block.
// ---------------------------------------------------------------------------
`default_nettype none

package amdfs_pkg;

  // Default graph size
  localparam int MAX_VERTICES_DEF = 16;

  // Configuration register
  localparam int          VCOUNT_W     = 5;
  localparam logic [4:0]  VCOUNT_RESET = 5'd16;

  // Command codes
  localparam logic [1:0] MODE_ADD  = 2'd0;
  localparam logic [1:0] MODE_DEL  = 2'd1;
  localparam logic [1:0] MODE_TRAV = 2'd2;

  // Command payload
  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] first_vertex;
    logic [3:0] second_vertex;
  } cmd_t;

  // Result payload
  typedef struct packed {
    logic [3:0] vertex;
    logic       last;
  } result_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_A,
    S_EDGE_B,
    S_SCAN,
    S_POP
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/adjacency_matrix_dfs.sv =====
// ---------------------------------------------------------------------------
// adjacency_matrix_dfs
// Undirected graph kept as an adjacency bit matrix, with depth-first search.
// ---------------------------------------------------------------------------
// Usage:
//   cmd is taken when start is high and busy is low. Modes add and delete set
//   or clear both mirror bits of an edge; an edge naming a vertex at or above
//   the vertex count is dropped, and so is the unused mode. Neither gives a
//   result. Mode traverse runs a DFS from vertex 0 and presents each visited
//   vertex on result for one cycle with result_valid; the final one has last.
//   The receiver cannot stall; results are simply presented.
//   cfg_data (vertex count) transfers when cfg_valid and cfg_ready are high;
//   cfg_ready is high while the block is idle.
// Sequencing:
//   An edge update holds busy through states S_EDGE_A and S_EDGE_B after the
//   transfer (read-modify-write of row a, then row b, through the matrix
//   memory, which has one read and one write port). A traversal pushes each
//   newly visited vertex in S_SCAN, backtracks through S_SCAN then S_POP,
//   and ends with a final pop in S_SCAN, paced by the registered row read.
// Reset:
//   rst clears the matrix (per-row valid bits), the stack depth and the
//   visited marks, and sets the vertex count to 16.
// ---------------------------------------------------------------------------
`default_nettype none

`include "adjacency_matrix_dfs_macros.svh"

module adjacency_matrix_dfs #(
  parameter int MAX_VERTICES = amdfs_pkg::MAX_VERTICES_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  amdfs_pkg::cmd_t      cmd,
  output logic                 result_valid,
  output amdfs_pkg::result_t   result,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [4:0]            cfg_data
);

  import amdfs_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);      // vertex index width
  localparam int DW = $clog2(MAX_VERTICES + 1);  // count / depth width

  // Control state
  state_t              state, state_next;
  logic [VCOUNT_W-1:0] vertex_count;
  logic [DW-1:0]       depth;
  logic [MAX_VERTICES-1:0] visited;
  logic [MAX_VERTICES-1:0] row_vld;

  // Payload registers
  logic [VW-1:0] ea, eb;
  logic          edel;
  logic [3:0]    pending;

  // Memories
  logic [MAX_VERTICES-1:0] rows [MAX_VERTICES];
  logic [VW-1:0]           stack_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_q;
  logic                    row_vq;
  logic [VW-1:0]           stack_q;

  // Memory ports and sequencer controls
  logic [VW-1:0]           row_ra, row_wa, stk_ra, stk_wa, stk_wd;
  logic                    row_we, stk_we;
  logic [MAX_VERTICES-1:0] row_wd;
  logic                    edge_load, trav_start, push, pop, finish;

  // Datapath
  logic [DW-1:0]           n_eff;
  logic [MAX_VERTICES-1:0] live, row_eff, cand;
  logic [VW-1:0]           next_v, a_v, b_v;
  logic [DW-1:0]           pop_idx;
  logic                    in_range, has_cand;

  // Effective vertex count
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = DW'(1);
    end else if (32'(vertex_count) > MAX_VERTICES) begin
      n_eff = DW'(MAX_VERTICES);
    end else begin
      n_eff = DW'(vertex_count);
    end
  end

  // Mask of vertices in use
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live[i] = (i < 32'(n_eff));
    end
  end

  assign a_v      = VW'(cmd.first_vertex);
  assign b_v      = VW'(cmd.second_vertex);
  assign in_range = (32'(cmd.first_vertex) < 32'(n_eff)) &&
                    (32'(cmd.second_vertex) < 32'(n_eff));

  // Row read data; rows never written read as zero
  assign row_eff  = row_vq ? row_q : '0;
  assign cand     = row_eff & live & ~visited;
  assign has_cand = (cand != '0);
  assign pop_idx  = DW'(depth - DW'(2));

  // Lowest-numbered candidate
  always_comb begin
    next_v = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) next_v = VW'(i);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if ((cmd.mode == MODE_ADD || cmd.mode == MODE_DEL) && in_range) begin
            state_next = S_EDGE_A;
          end else if (cmd.mode == MODE_TRAV) begin
            state_next = S_SCAN;
          end
        end
      end
      S_EDGE_A: state_next = S_EDGE_B;
      S_EDGE_B: state_next = S_IDLE;
      S_SCAN: begin
        if (has_cand) begin
          state_next = S_SCAN;
        end else if (depth == DW'(1)) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_POP;
        end
      end
      S_POP:    state_next = S_SCAN;
      default:  state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    row_ra     = '0;
    row_we     = 1'b0;
    row_wa     = '0;
    row_wd     = '0;
    stk_ra     = '0;
    stk_we     = 1'b0;
    stk_wa     = '0;
    stk_wd     = '0;
    edge_load  = 1'b0;
    trav_start = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if ((cmd.mode == MODE_ADD || cmd.mode == MODE_DEL) && in_range) begin
            edge_load = 1'b1;
            row_ra    = a_v;
          end else if (cmd.mode == MODE_TRAV) begin
            trav_start = 1'b1;
            stk_we     = 1'b1;
            row_ra     = '0;
          end
        end
      end
      S_EDGE_A: begin
        row_we = 1'b1;
        row_wa = ea;
        row_wd = edel ? (row_eff & ~(MAX_VERTICES'(1) << eb))
                      : (row_eff | (MAX_VERTICES'(1) << eb));
        row_ra = eb;
      end
      S_EDGE_B: begin
        row_we = 1'b1;
        row_wa = eb;
        row_wd = edel ? (row_eff & ~(MAX_VERTICES'(1) << ea))
                      : (row_eff | (MAX_VERTICES'(1) << ea));
      end
      S_SCAN: begin
        if (has_cand) begin
          push   = 1'b1;
          stk_we = 1'b1;
          stk_wa = depth[VW-1:0];
          stk_wd = next_v;
          row_ra = next_v;
        end else if (depth == DW'(1)) begin
          finish = 1'b1;
        end else begin
          pop    = 1'b1;
          stk_ra = pop_idx[VW-1:0];
        end
      end
      S_POP: begin
        row_ra = stack_q;
      end
      default: begin
        row_ra = '0;
      end
    endcase
  end

  // Matrix memory, registered read
  always_ff @(posedge clk) begin
    if (row_we) rows[row_wa] <= row_wd;
    row_q <= rows[row_ra];
  end

  // Stack memory, registered read
  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stack_q <= stack_mem[stk_ra];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= VCOUNT_RESET;
      depth        <= '0;
      visited      <= '0;
      row_vld      <= '0;
      row_vq       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      row_vq       <= row_vld[row_ra];
      result_valid <= push || finish;
      if (cfg_valid && cfg_ready) vertex_count <= cfg_data;
      if (row_we) row_vld[row_wa] <= 1'b1;
      if (trav_start) begin
        depth   <= DW'(1);
        visited <= MAX_VERTICES'(1);
      end else if (push) begin
        depth   <= DW'(depth + DW'(1));
        visited <= visited | (MAX_VERTICES'(1) << next_v);
      end else if (pop || finish) begin
        depth   <= DW'(depth - DW'(1));
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (edge_load) begin
      ea   <= a_v;
      eb   <= b_v;
      edel <= (cmd.mode == MODE_DEL);
    end
    if (trav_start) begin
      pending <= '0;
    end else if (push) begin
      pending <= 4'(next_v);
    end
    if (push || finish) begin
      result.vertex <= pending;
      result.last   <= finish;
    end
  end

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Checks
  `AMD_ASSERT_IMP(a_last_idle, result_valid && result.last, state == S_IDLE, "last result while busy")
  `AMD_ASSERT_IMP(a_mid_busy, result_valid && !result.last, busy, "traversal ended without last")
  `AMD_ASSERT_IMP(a_idle_empty, state == S_IDLE, depth == '0, "stack not empty when idle")
  `AMD_ASSERT_IMP(a_scan_depth, state == S_SCAN || state == S_POP, depth != '0, "empty stack in traversal")
  `AMD_ASSERT_NXT(a_trav_start, start && !busy && cmd.mode == MODE_TRAV, state == S_SCAN, "traversal did not start")

endmodule

`default_nettype wire
